[rtl/core/sbp_pkg.sv]
// Shared types, widths and helper functions for the sphere against box push-out block.
// Depends on nothing; sbp_front, sbp_sqrt, sbp_div and sphere_box_pushout import it.
package sbp_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned RAD_W = 31;
   localparam int unsigned DIFF_W = 33;
   localparam int unsigned SQ_W = 64;
   localparam int unsigned SUM_W = 66;
   localparam int unsigned NRAD_W = 62;
   localparam int unsigned ROOT_W = 31;

   // Epsilon 0.00001 expressed in Q32.32.
   localparam logic [SUM_W-1:0] EPS_Q32 = 66'd42950;

   localparam int unsigned FRONT_STAGES = 5;
   localparam int unsigned SQRT_STEPS = 31;
   localparam int unsigned DIV_STEPS = 31;
   localparam int unsigned NUM_AXES = 3;
   localparam int unsigned NUM_FACES = 6;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [2:0] FACE_ZMAX = 3'd0;
   localparam logic [2:0] FACE_ZMIN = 3'd1;
   localparam logic [2:0] FACE_XMAX = 3'd2;
   localparam logic [2:0] FACE_XMIN = 3'd3;
   localparam logic [2:0] FACE_YMAX = 3'd4;
   localparam logic [2:0] FACE_YMIN = 3'd5;

   localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
   localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

   // Request payload as it enters the pipeline.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
      logic signed [31:0] box_min_x;
      logic signed [31:0] box_min_y;
      logic signed [31:0] box_min_z;
      logic signed [31:0] box_max_x;
      logic signed [31:0] box_max_y;
      logic signed [31:0] box_max_z;
   } sbp_req_type;

   // Sideband that rides along the square root pipeline.
   typedef struct packed {
      logic               outside;
      logic               hit;
      logic [1:0]         axis;
      logic signed [31:0] inside_push;
      logic [2:0]         dneg;
      logic [2:0][30:0]   dmag;
      logic [30:0]        radius;
   } sbp_side_type;

   // Sideband that rides along the divider pipeline.
   typedef struct packed {
      logic               outside;
      logic               hit;
      logic [1:0]         axis;
      logic signed [31:0] inside_push;
      logic [2:0]         dneg;
   } sbp_tail_type;

   function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
      return {v[31], v};
   endfunction

   // Axis that a face belongs to.
   function automatic logic [1:0] face_axis(input logic [2:0] face);
      logic [1:0] ax;
      unique case (face) inside
         FACE_ZMAX, FACE_ZMIN: ax = AXIS_Z;
         FACE_XMAX, FACE_XMIN: ax = AXIS_X;
         FACE_YMAX, FACE_YMIN: ax = AXIS_Y;
         default:              ax = AXIS_Y;
      endcase
      return ax;
   endfunction

   // Minimum faces push in the negative direction.
   function automatic logic face_is_min(input logic [2:0] face);
      return (face == FACE_ZMIN) || (face == FACE_XMIN) || (face == FACE_YMIN);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/core/sbp_if.sv]
// Valid/ready channel interfaces for the request and response sides of the block.
// Depends on nothing.
interface sbp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] center_z;
   logic [30:0]        radius;
   logic signed [31:0] box_min_x;
   logic signed [31:0] box_min_y;
   logic signed [31:0] box_min_z;
   logic signed [31:0] box_max_x;
   logic signed [31:0] box_max_y;
   logic signed [31:0] box_max_z;

   modport source (output valid, center_x, center_y, center_z, radius,
                   box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, radius,
                 box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                 output ready);
endinterface

interface sbp_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] push_x;
   logic signed [31:0] push_y;
   logic signed [31:0] push_z;

   modport source (output valid, hit, push_x, push_y, push_z, input ready);
   modport sink (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

[rtl/core/sbp_front.sv]
// Front pipeline: clamp, squared distance, hit tests and nearest face selection.
// Depends on sbp_pkg.
module sbp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  sbp_pkg::sbp_req_type          in_req,
   output logic                          out_valid,
   output sbp_pkg::sbp_side_type         out_side,
   output logic [sbp_pkg::NRAD_W-1:0]    out_n
);
   import sbp_pkg::*;

   logic [FRONT_STAGES-1:0] vld_ff;

   logic signed [31:0] c_w [NUM_AXES];
   logic signed [31:0] lo_w [NUM_AXES];
   logic signed [31:0] hi_w [NUM_AXES];
   logic signed [32:0] diff_in [NUM_AXES];
   logic signed [32:0] fd_in [NUM_FACES];

   logic signed [32:0] s1_diff_ff [NUM_AXES];
   logic signed [32:0] s1_fd_ff [NUM_FACES];
   logic [30:0]        s1_r_ff;

   logic [31:0]        s2_mag_ff [NUM_AXES];
   logic [2:0]         s2_neg_ff;
   logic signed [32:0] s2_wfd_ff [NUM_AXES];
   logic [2:0]         s2_widx_ff [NUM_AXES];
   logic [30:0]        s2_r_ff;

   logic [SQ_W-1:0]    s3_sq_ff [NUM_AXES];
   logic [NRAD_W-1:0]  s3_r2_ff;
   logic signed [32:0] s3_bfd_ff;
   logic [2:0]         s3_bidx_ff;
   logic [2:0]         s3_neg_ff;
   logic [2:0][30:0]   s3_dmag_ff;
   logic [30:0]        s3_r_ff;

   logic [SUM_W-1:0]   s4_sum_ff;
   logic [NRAD_W-1:0]  s4_r2_ff;
   logic signed [33:0] s4_raw_ff;
   logic [2:0]         s4_bidx_ff;
   logic [2:0]         s4_neg_ff;
   logic [2:0][30:0]   s4_dmag_ff;
   logic [30:0]        s4_r_ff;

   sbp_side_type       s5_side_ff;
   logic [NRAD_W-1:0]  s5_n_ff;

   assign c_w[0] = in_req.center_x;
   assign c_w[1] = in_req.center_y;
   assign c_w[2] = in_req.center_z;
   assign lo_w[0] = in_req.box_min_x;
   assign lo_w[1] = in_req.box_min_y;
   assign lo_w[2] = in_req.box_min_z;
   assign hi_w[0] = in_req.box_max_x;
   assign hi_w[1] = in_req.box_max_y;
   assign hi_w[2] = in_req.box_max_z;

   // Valid bits advance with the data whenever the pipeline moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   // Stage 1: clamp the center into the box and form the face distances.
   always_comb begin
      logic signed [31:0] mn;
      logic signed [31:0] cl;
      for (int a = 0; a < NUM_AXES; a++) begin
         mn = (c_w[a] < hi_w[a]) ? c_w[a] : hi_w[a];
         cl = (lo_w[a] > mn) ? lo_w[a] : mn;
         diff_in[a] = sx33(c_w[a]) - sx33(cl);
      end
      fd_in[FACE_ZMAX] = sx33(hi_w[2]) - sx33(c_w[2]);
      fd_in[FACE_ZMIN] = sx33(c_w[2]) - sx33(lo_w[2]);
      fd_in[FACE_XMAX] = sx33(hi_w[0]) - sx33(c_w[0]);
      fd_in[FACE_XMIN] = sx33(c_w[0]) - sx33(lo_w[0]);
      fd_in[FACE_YMAX] = sx33(hi_w[1]) - sx33(c_w[1]);
      fd_in[FACE_YMIN] = sx33(c_w[1]) - sx33(lo_w[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_diff_ff <= diff_in;
         s1_fd_ff <= fd_in;
         s1_r_ff <= in_req.radius;
      end
   end

   // Stage 2: magnitudes and the first round of face comparisons by pairs.
   always_ff @(posedge clock) begin
      logic signed [32:0] ab;
      if (en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            ab = s1_diff_ff[a][32] ? -s1_diff_ff[a] : s1_diff_ff[a];
            s2_mag_ff[a] <= ab[31:0];
            s2_neg_ff[a] <= s1_diff_ff[a][32];
            if (s1_fd_ff[2*a+1] < s1_fd_ff[2*a]) begin
               s2_wfd_ff[a] <= s1_fd_ff[2*a+1];
               s2_widx_ff[a] <= 3'(2*a+1);
            end else begin
               s2_wfd_ff[a] <= s1_fd_ff[2*a];
               s2_widx_ff[a] <= 3'(2*a);
            end
         end
         s2_r_ff <= s1_r_ff;
      end
   end

   // Stage 3: squares, radius squared, and the final face choice.
   // A later face wins only when strictly nearer.
   always_ff @(posedge clock) begin
      logic signed [32:0] bf;
      logic [2:0]         bi;
      if (en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            s3_sq_ff[a] <= s2_mag_ff[a] * s2_mag_ff[a];
            s3_dmag_ff[a] <= s2_mag_ff[a][30:0];
         end
         s3_r2_ff <= NRAD_W'(s2_r_ff) * NRAD_W'(s2_r_ff);
         bf = s2_wfd_ff[0];
         bi = s2_widx_ff[0];
         if (s2_wfd_ff[1] < bf) begin
            bf = s2_wfd_ff[1];
            bi = s2_widx_ff[1];
         end
         if (s2_wfd_ff[2] < bf) begin
            bf = s2_wfd_ff[2];
            bi = s2_widx_ff[2];
         end
         s3_bfd_ff <= bf;
         s3_bidx_ff <= bi;
         s3_neg_ff <= s2_neg_ff;
         s3_r_ff <= s2_r_ff;
      end
   end

   // Stage 4: sum of squares and the unsigned inside push length.
   always_ff @(posedge clock) begin
      if (en) begin
         s4_sum_ff <= SUM_W'(s3_sq_ff[0]) + SUM_W'(s3_sq_ff[1]) + SUM_W'(s3_sq_ff[2]);
         s4_raw_ff <= {s3_bfd_ff[32], s3_bfd_ff} + $signed({3'b000, s3_r_ff});
         s4_r2_ff <= s3_r2_ff;
         s4_bidx_ff <= s3_bidx_ff;
         s4_neg_ff <= s3_neg_ff;
         s4_dmag_ff <= s3_dmag_ff;
         s4_r_ff <= s3_r_ff;
      end
   end

   // Stage 5: epsilon and radius tests, signed and saturated inside push.
   always_ff @(posedge clock) begin
      logic signed [34:0] v;
      logic               outside;
      if (en) begin
         outside = (s4_sum_ff >= EPS_Q32);
         v = {s4_raw_ff[33], s4_raw_ff};
         if (face_is_min(s4_bidx_ff)) begin
            v = -v;
         end
         s5_side_ff.outside <= outside;
         s5_side_ff.hit <= outside ? (s4_sum_ff < SUM_W'(s4_r2_ff)) : 1'b1;
         s5_side_ff.axis <= face_axis(s4_bidx_ff);
         s5_side_ff.inside_push <= sat32(v);
         s5_side_ff.dneg <= s4_neg_ff;
         s5_side_ff.dmag <= s4_dmag_ff;
         s5_side_ff.radius <= s4_r_ff;
         s5_n_ff <= s4_sum_ff[NRAD_W-1:0];
      end
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_side = s5_side_ff;
   assign out_n = s5_n_ff;

   // A center on the inside path always counts as a hit.
   a_inside_hits: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_side.outside |-> out_side.hit)
      else $error("inside transaction without hit");

endmodule

[rtl/core/sbp_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband carried along.
// Depends on sbp_pkg.
module sbp_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  sbp_pkg::sbp_side_type         in_side,
   input  logic [sbp_pkg::NRAD_W-1:0]    in_n,
   output logic                          out_valid,
   output sbp_pkg::sbp_side_type         out_side,
   output logic [sbp_pkg::ROOT_W-1:0]    out_root
);
   import sbp_pkg::*;

   logic [SQRT_STEPS-1:0] vld_ff;
   logic [32:0]           rem_ff [SQRT_STEPS];
   logic [ROOT_W-1:0]     root_ff [SQRT_STEPS];
   logic [NRAD_W-1:0]     n_ff [SQRT_STEPS];
   sbp_side_type          side_ff [SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   // Each stage brings down two radicand bits and decides one root bit.
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [32:0]       rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [NRAD_W-1:0] n_src;
      sbp_side_type      side_src;
      logic [34:0]       cur;
      logic [34:0]       trial;
      logic [34:0]       sub;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_src = '0;
         assign root_src = '0;
         assign n_src = in_n;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign n_src = n_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign cur = {rem_src, n_src[NRAD_W-1:NRAD_W-2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign ge = (cur >= trial);
      assign sub = cur - trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? sub[32:0] : cur[32:0];
            root_ff[k] <= {root_src[ROOT_W-2:0], ge};
            n_ff[k] <= {n_src[NRAD_W-3:0], 2'b00};
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_side = side_ff[SQRT_STEPS-1];
   assign out_root = root_ff[SQRT_STEPS-1];

   // A held pipeline keeps its occupancy.
   a_sqrt_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("square root pipeline moved while stalled");

endmodule

[rtl/core/sbp_div.sv]
// Penetration, products and three pipelined restoring dividers sharing one divisor.
// Depends on sbp_pkg.
module sbp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  sbp_pkg::sbp_side_type         in_side,
   input  logic [sbp_pkg::ROOT_W-1:0]    in_root,
   output logic                          out_valid,
   output sbp_pkg::sbp_tail_type         out_tail,
   output logic [2:0][30:0]              out_quot
);
   import sbp_pkg::*;

   logic [DIV_STEPS+1:0] vld_ff;

   logic [30:0]        p_pen_ff;
   logic [ROOT_W-1:0]  p_d_ff;
   logic [2:0][30:0]   p_dmag_ff;
   sbp_tail_type       p_tail_ff;

   logic [NRAD_W-1:0]  m_prod_ff [NUM_AXES];
   logic [ROOT_W-1:0]  m_d_ff;
   sbp_tail_type       m_tail_ff;

   logic [30:0]        rem_ff [DIV_STEPS][NUM_AXES];
   logic [30:0]        low_ff [DIV_STEPS][NUM_AXES];
   logic [30:0]        q_ff [DIV_STEPS][NUM_AXES];
   logic [ROOT_W-1:0]  d_ff [DIV_STEPS];
   sbp_tail_type       tail_ff [DIV_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DIV_STEPS:0], in_valid};
      end
   end

   // Penetration depth, radius minus distance.
   always_ff @(posedge clock) begin
      if (en) begin
         p_pen_ff <= in_side.radius - in_root;
         p_d_ff <= in_root;
         p_dmag_ff <= in_side.dmag;
         p_tail_ff.outside <= in_side.outside;
         p_tail_ff.hit <= in_side.hit;
         p_tail_ff.axis <= in_side.axis;
         p_tail_ff.inside_push <= in_side.inside_push;
         p_tail_ff.dneg <= in_side.dneg;
      end
   end

   // Dividend magnitudes, offset times penetration.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            m_prod_ff[a] <= NRAD_W'(p_dmag_ff[a]) * NRAD_W'(p_pen_ff);
         end
         m_d_ff <= p_d_ff;
         m_tail_ff <= p_tail_ff;
      end
   end

   // One quotient bit per stage and lane; the remainder stays below the divisor.
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [ROOT_W-1:0] d_src;
      sbp_tail_type      tail_src;

      if (k == 0) begin : g_first_ctl
         assign d_src = m_d_ff;
         assign tail_src = m_tail_ff;
      end else begin : g_next_ctl
         assign d_src = d_ff[k-1];
         assign tail_src = tail_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[k] <= d_src;
            tail_ff[k] <= tail_src;
         end
      end

      for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
         logic [30:0] rem_src;
         logic [30:0] low_src;
         logic [30:0] q_src;
         logic [31:0] cur;
         logic [31:0] sub;
         logic        ge;

         if (k == 0) begin : g_first
            assign rem_src = m_prod_ff[a][61:31];
            assign low_src = m_prod_ff[a][30:0];
            assign q_src = '0;
         end else begin : g_next
            assign rem_src = rem_ff[k-1][a];
            assign low_src = low_ff[k-1][a];
            assign q_src = q_ff[k-1][a];
         end

         assign cur = {rem_src, low_src[30]};
         assign ge = (cur >= {1'b0, d_src});
         assign sub = cur - {1'b0, d_src};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][a] <= ge ? sub[30:0] : cur[30:0];
               low_ff[k][a] <= {low_src[29:0], 1'b0};
               q_ff[k][a] <= {q_src[29:0], ge};
            end
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS+1];
   assign out_tail = tail_ff[DIV_STEPS-1];
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_out
      assign out_quot[a] = q_ff[DIV_STEPS-1][a];
   end

   // A held pipeline keeps its occupancy.
   a_div_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("divider pipeline moved while stalled");

endmodule

[rtl/core/sphere_box_pushout.sv]
// Top level of the sphere against axis-aligned box push-out pipeline.
// Depends on sbp_pkg, sbp_if, sbp_front, sbp_sqrt and sbp_div.

// Accepts one sphere/box transaction per cycle while the response side does not
// stall, and returns one response per transaction, in order. The pipeline holds
// five front stages (clamp, squares, sum, tests), a 31-stage square root that
// yields one distance bit per stage, two stages for penetration and products,
// a 31-stage divider that yields one quotient bit per stage for all three axes
// at once, and the response register. All stages advance together; a stalled
// response holds the whole pipeline in place.
module sphere_box_pushout (
   input logic        clock,
   input logic        reset,
   sbp_req_if.sink    req_ch,
   sbp_rsp_if.source  rsp_ch
);
   import sbp_pkg::*;

   logic          en;
   sbp_req_type   req_data;

   logic          front_valid;
   sbp_side_type  front_side;
   logic [NRAD_W-1:0] front_n;

   logic          sqrt_valid;
   sbp_side_type  sqrt_side;
   logic [ROOT_W-1:0] sqrt_root;

   logic          div_valid;
   sbp_tail_type  div_tail;
   logic [2:0][30:0] div_quot;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic signed [31:0] rsp_push_ff [NUM_AXES];
   logic signed [31:0] rsp_push_in [NUM_AXES];

   // The pipeline moves whenever the response register is free or drains.
   assign en = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   assign req_data.center_x = req_ch.center_x;
   assign req_data.center_y = req_ch.center_y;
   assign req_data.center_z = req_ch.center_z;
   assign req_data.radius = req_ch.radius;
   assign req_data.box_min_x = req_ch.box_min_x;
   assign req_data.box_min_y = req_ch.box_min_y;
   assign req_data.box_min_z = req_ch.box_min_z;
   assign req_data.box_max_x = req_ch.box_max_x;
   assign req_data.box_max_y = req_ch.box_max_y;
   assign req_data.box_max_z = req_ch.box_max_z;

   sbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_req    (req_data),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_n     (front_n)
   );

   sbp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_n      (front_n),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_root  (sqrt_root)
   );

   sbp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_side   (sqrt_side),
      .in_root   (sqrt_root),
      .out_valid (div_valid),
      .out_tail  (div_tail),
      .out_quot  (div_quot)
   );

   // Pick the inside face push, the signed outside push, or zero.
   always_comb begin
      logic signed [31:0] q;
      for (int a = 0; a < NUM_AXES; a++) begin
         q = {1'b0, div_quot[a]};
         if (!div_tail.outside) begin
            rsp_push_in[a] = (div_tail.axis == 2'(a)) ? div_tail.inside_push : '0;
         end else if (div_tail.hit) begin
            rsp_push_in[a] = div_tail.dneg[a] ? -q : q;
         end else begin
            rsp_push_in[a] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= div_tail.hit;
         rsp_push_ff <= rsp_push_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.hit = rsp_hit_ff;
   assign rsp_ch.push_x = rsp_push_ff[0];
   assign rsp_ch.push_y = rsp_push_ff[1];
   assign rsp_ch.push_z = rsp_push_ff[2];

   // A miss never carries a push.
   a_miss_no_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |->
         (rsp_push_ff[0] == 0) && (rsp_push_ff[1] == 0) && (rsp_push_ff[2] == 0))
      else $error("push on a missed transaction");

endmodule
